// ----- hw/rtl/bss_pkg.sv -----
`default_nettype none

package bss_pkg;

	// Fixed datapath widths.
	localparam int DUTY_WIDTH      = 16;
	localparam int TICK_WIDTH      = 20;
	localparam int INTERVAL_WIDTH  = 5;
	localparam int EDGE_WIDTH      = 8;
	localparam int HALL_WIDTH      = 3;
	localparam int POSITION_WIDTH  = 8;
	localparam int PRODUCT_WIDTH   = DUTY_WIDTH + POSITION_WIDTH;
	localparam int CFG_INDEX_WIDTH = 8;
	localparam int CFG_DATA_WIDTH  = 20;

	// Test timing and slider scale.
	localparam int STEP_INTERVALS = 20;
	localparam int STEP_SIZE      = 20;
	localparam int SLIDER_FULL    = 255;

	// Register values after reset.
	localparam logic [DUTY_WIDTH-1:0] PERIOD_RESET   = 16'd1000;
	localparam logic [DUTY_WIDTH-1:0] MIN_DUTY_RESET = 16'd0;
	localparam logic [TICK_WIDTH-1:0] TICKS_RESET    = 20'd1000;

	typedef enum logic [2:0] {
		OP_HALL_EDGE    = 3'd0,
		OP_PWM_TICK     = 3'd1,
		OP_DUTY_UP      = 3'd2,
		OP_DUTY_DOWN    = 3'd3,
		OP_STOP         = 3'd4,
		OP_SET_POSITION = 3'd5,
		OP_START_TEST   = 3'd6,
		OP_REFRESH      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		TEST_NONE = 2'd0,
		TEST_RAMP = 2'd1,
		TEST_STEP = 2'd2
	} test_mode_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_PERIOD   = 8'd0,
		CFG_MIN_DUTY = 8'd1,
		CFG_TICKS    = 8'd2,
		CFG_REVERSE  = 8'd3
	} cfg_index_t;

	typedef struct packed {
		op_t                     op;
		logic [HALL_WIDTH-1:0]   hall_bits;
		logic [POSITION_WIDTH-1:0] position;
		logic [1:0]              test_select;
	} cmd_t;

	typedef struct packed {
		logic [DUTY_WIDTH-1:0] duty_a;
		logic [DUTY_WIDTH-1:0] duty_b;
		logic [DUTY_WIDTH-1:0] duty_c;
		logic                  enable_a;
		logic                  enable_b;
		logic                  enable_c;
		logic [2:0]            phase_number;
		logic                  running;
		logic [DUTY_WIDTH-1:0] duty_now;
	} rsp_t;

	// Hall code after direction inversion to phase; zero marks an invalid code.
	function automatic logic [2:0] code_to_phase(logic [HALL_WIDTH-1:0] code);
		logic [2:0] ph;
		case (code)
			3'd1:    ph = 3'd2;
			3'd2:    ph = 3'd4;
			3'd3:    ph = 3'd3;
			3'd4:    ph = 3'd6;
			3'd5:    ph = 3'd1;
			3'd6:    ph = 3'd5;
			default: ph = 3'd0;
		endcase
		return ph;
	endfunction

	// Driver enables per phase, ordered {C, B, A}.
	function automatic logic [2:0] phase_enables(logic [2:0] ph);
		logic [2:0] en;
		case (ph)
			3'd1, 3'd4: en = 3'b011;
			3'd2, 3'd5: en = 3'b101;
			3'd3, 3'd6: en = 3'b110;
			default:    en = 3'b000;
		endcase
		return en;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bss_if.sv -----
`default_nettype none

// Command channel into the commutator.
interface bss_cmd_if;
	import bss_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel out of the commutator.
interface bss_rsp_if;
	import bss_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bldc_six_step_commutator_core.sv -----
// A command transfer is captured in the input stage register; the execute stage then
// writes its result into the output register, which drives rsp.
// Throughput: one command per cycle unless rsp stalls; the execute stage updates all state together.
// The slider product is formed while the command enters the input stage register.
// Reset clears the pipeline, the counters and the commutation state at once,
// and loads the configuration registers with their default values.
`default_nettype none

module bldc_six_step_commutator_core #(
	parameter int STEP_INTERVALS = bss_pkg::STEP_INTERVALS,
	parameter int STEP_SIZE      = bss_pkg::STEP_SIZE
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [bss_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire [bss_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
	bss_cmd_if.sink                             cmd,
	bss_rsp_if.source                           rsp
);
	import bss_pkg::*;

	// Exact floor(x / 255) for a 24-bit x with a 16-bit quotient: the residue comes from the base-256
	// digit sum, and the exact quotient of (x - residue) is a multiply by the
	// inverse of 255 modulo 2^16, which is -(1 + 2^8).
	function automatic logic [DUTY_WIDTH-1:0] div_by_full(logic [PRODUCT_WIDTH-1:0] x);
		logic [9:0]               digit_sum;
		logic [8:0]               folded;
		logic [7:0]               rem;
		logic [PRODUCT_WIDTH-1:0] z;
		logic [DUTY_WIDTH-1:0]    t;
		digit_sum = 10'(x[7:0]) + 10'(x[15:8]) + 10'(x[23:16]);
		folded    = 9'(digit_sum[7:0]) + 9'(digit_sum[9:8]);
		rem       = (folded >= 9'(SLIDER_FULL)) ? 8'(folded - 9'(SLIDER_FULL)) : folded[7:0];
		z         = x - PRODUCT_WIDTH'(rem);
		t         = z[DUTY_WIDTH-1:0] + {z[7:0], 8'h00};
		return DUTY_WIDTH'(16'd0 - t);
	endfunction

	// Configuration registers.
	logic [DUTY_WIDTH-1:0] period_q;
	logic [DUTY_WIDTH-1:0] min_duty_q;
	logic [TICK_WIDTH-1:0] ticks_q;
	logic                  reverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_RESET;
			min_duty_q <= MIN_DUTY_RESET;
			ticks_q    <= TICKS_RESET;
			reverse_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PERIOD:   period_q   <= cfg_wdata[DUTY_WIDTH-1:0];
				CFG_MIN_DUTY: min_duty_q <= cfg_wdata[DUTY_WIDTH-1:0];
				CFG_TICKS:    ticks_q    <= cfg_wdata[TICK_WIDTH-1:0];
				CFG_REVERSE:  reverse_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Input stage: the command and the slider product.
	logic                     valid_s1;
	op_t                      op_s1;
	logic [HALL_WIDTH-1:0]    hall_s1;
	logic [1:0]               sel_s1;
	logic [PRODUCT_WIDTH-1:0] product_s1;
	logic                     valid_s2;
	rsp_t                     rsp_s2;
	logic                     fire_s1;

	assign fire_s1   = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1      <= cmd.data.op;
			hall_s1    <= cmd.data.hall_bits;
			sel_s1     <= cmd.data.test_select;
			product_s1 <= PRODUCT_WIDTH'(cmd.data.position) * PRODUCT_WIDTH'(period_q);
		end
	end

	// Controller state.
	logic [TICK_WIDTH-1:0]     tick_q;
	logic [INTERVAL_WIDTH-1:0] interval_q;
	logic                      ramp_q;
	logic [DUTY_WIDTH-1:0]     duty_q;
	test_mode_t                test_q;
	logic [EDGE_WIDTH-1:0]     edge_q;
	logic                      running_q;
	logic [2:0]                phase_q;
	logic [DUTY_WIDTH-1:0]     cduty_q;

	logic [TICK_WIDTH-1:0]     n_tick;
	logic [INTERVAL_WIDTH-1:0] n_interval;
	logic                      n_ramp;
	logic [DUTY_WIDTH-1:0]     n_duty;
	test_mode_t                n_test;
	logic [EDGE_WIDTH-1:0]     n_edge;
	logic                      n_running;
	logic [2:0]                n_phase;
	logic [DUTY_WIDTH-1:0]     n_cduty;

	// Values derived from the current state.
	logic [TICK_WIDTH-1:0]     tick_inc;
	logic [INTERVAL_WIDTH-1:0] interval_inc;
	logic                      step_due;
	logic [2:0]                decoded_phase;
	logic [DUTY_WIDTH-1:0]     rise_room;
	logic [DUTY_WIDTH-1:0]     fall_room;
	logic [DUTY_WIDTH-1:0]     slider_duty;
	logic                      commutate_en;
	logic                      ramp_en;
	logic [DUTY_WIDTH-1:0]     ramp_amount;

	assign tick_inc      = tick_q + 1'b1;
	assign interval_inc  = interval_q + 1'b1;
	assign step_due      = interval_inc >= INTERVAL_WIDTH'(STEP_INTERVALS);
	assign decoded_phase = code_to_phase(hall_s1 ^ {HALL_WIDTH{reverse_q}});
	assign rise_room     = period_q - duty_q;
	assign fall_room     = duty_q - min_duty_q;
	assign slider_duty   = div_by_full(product_s1);

	// Next state for the command in the input stage.
	always_comb begin
		n_tick       = tick_q;
		n_interval   = interval_q;
		n_ramp       = ramp_q;
		n_duty       = duty_q;
		n_test       = test_q;
		n_edge       = edge_q;
		n_running    = running_q;
		n_phase      = phase_q;
		n_cduty      = cduty_q;
		commutate_en = 1'b0;
		ramp_en      = 1'b0;
		ramp_amount  = (test_q == TEST_RAMP) ? DUTY_WIDTH'(1) : DUTY_WIDTH'(STEP_SIZE);

		case (op_s1)
			OP_HALL_EDGE: begin
				commutate_en = 1'b1;
				if (edge_q != '1) begin
					n_edge = edge_q + 1'b1;
				end
			end
			OP_PWM_TICK: begin
				if (tick_inc < ticks_q) begin
					n_tick = tick_inc;
				end else begin
					// End of an interval: sample activity and advance the tests.
					n_tick    = '0;
					n_running = (edge_q != '0);
					n_edge    = '0;
					n_interval = step_due ? '0 : interval_inc;
					ramp_en   = (test_q == TEST_RAMP) || ((test_q == TEST_STEP) && step_due);
				end
			end
			OP_DUTY_UP: begin
				if (duty_q < period_q) begin
					n_duty = duty_q + 1'b1;
				end
			end
			OP_DUTY_DOWN: begin
				if (duty_q > min_duty_q) begin
					n_duty = duty_q - 1'b1;
				end
			end
			OP_STOP: begin
				n_test = TEST_NONE;
				n_duty = '0;
			end
			OP_SET_POSITION: begin
				n_duty = slider_duty;
			end
			OP_START_TEST: begin
				if (sel_s1 inside {2'd1, 2'd2}) begin
					n_test = test_mode_t'(sel_s1);
				end
			end
			OP_REFRESH: begin
				commutate_en = !running_q && (duty_q != '0);
			end
			default: ;
		endcase

		// Ramp or step move; at a bound the direction turns instead.
		if (ramp_en) begin
			if (ramp_q) begin
				if (duty_q < period_q) begin
					n_duty = (ramp_amount >= rise_room) ? period_q : duty_q + ramp_amount;
				end else begin
					n_ramp = 1'b0;
				end
			end else begin
				if (duty_q > min_duty_q) begin
					n_duty = (ramp_amount >= fall_room) ? min_duty_q : duty_q - ramp_amount;
				end else begin
					n_ramp = 1'b1;
				end
			end
		end

		// Commutation on a valid hall code latches the commanded duty.
		if (commutate_en && (decoded_phase != 3'd0)) begin
			n_phase = decoded_phase;
			n_cduty = duty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			interval_q <= '0;
			ramp_q     <= 1'b1;
			duty_q     <= '0;
			test_q     <= TEST_NONE;
			edge_q     <= '0;
			running_q  <= 1'b0;
			phase_q    <= 3'd0;
			cduty_q    <= '0;
		end else if (fire_s1) begin
			tick_q     <= n_tick;
			interval_q <= n_interval;
			ramp_q     <= n_ramp;
			duty_q     <= n_duty;
			test_q     <= n_test;
			edge_q     <= n_edge;
			running_q  <= n_running;
			phase_q    <= n_phase;
			cduty_q    <= n_cduty;
		end
	end

	// Result built from the state after the command.
	rsp_t       rsp_next;
	logic [2:0] enables;

	assign enables = phase_enables(n_phase);

	always_comb begin
		rsp_next.duty_a       = ((n_phase == 3'd1) || (n_phase == 3'd2)) ? n_cduty : '0;
		rsp_next.duty_b       = ((n_phase == 3'd3) || (n_phase == 3'd4)) ? n_cduty : '0;
		rsp_next.duty_c       = ((n_phase == 3'd5) || (n_phase == 3'd6)) ? n_cduty : '0;
		rsp_next.enable_a     = enables[0];
		rsp_next.enable_b     = enables[1];
		rsp_next.enable_c     = enables[2];
		rsp_next.phase_number = n_phase;
		rsp_next.running      = n_running;
		rsp_next.duty_now     = n_duty;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none

module tb_top;
	import bss_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 300;

	// Receiver stall styles.
	localparam int RX_OPEN     = 0;
	localparam int RX_RANDOM   = 1;
	localparam int RX_PERIODIC = 2;

	// Register index outside the mapped set, and the test select with no test behind it.
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED = 8'hFF;
	localparam logic [1:0] TEST_INVALID = 2'd3;

	// The two hall codes that never name a phase.
	localparam logic [HALL_WIDTH-1:0] HALL_ALL_LOW  = 3'b000;
	localparam logic [HALL_WIDTH-1:0] HALL_ALL_HIGH = 3'b111;

	// Hall code to phase, three bits per entry, code 0 in the lowest slot.
	localparam logic [23:0] CODE_PHASES = {3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd0};
	// Hall codes of phases 1 to 6 in rotation order, phase 1 in the lowest slot.
	localparam logic [17:0] ROTOR_CODES = {3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5};

	// Predicts the drive outputs from each command and checks the results against them.
	class commutation_checker;
		logic [DUTY_WIDTH-1:0] period;
		logic [DUTY_WIDTH-1:0] floor_duty;
		logic [TICK_WIDTH-1:0] interval_ticks;
		logic reverse;
		logic [TICK_WIDTH-1:0] tick_cnt;
		logic [INTERVAL_WIDTH-1:0] interval_cnt;
		logic rising;
		logic [DUTY_WIDTH-1:0] duty;
		test_mode_t mode;
		logic [EDGE_WIDTH-1:0] edges;
		logic running;
		logic [2:0] phase;
		logic [DUTY_WIDTH-1:0] latched;
		rsp_t pending_drives[$];
		int errors;
		int results;
		int commands;
		int intervals;
		int ramp_moves;
		int step_moves;
		int turns;
		int phase_moves;

		function new();
			period = PERIOD_RESET;
			floor_duty = MIN_DUTY_RESET;
			interval_ticks = TICKS_RESET;
			reverse = 1'b0;
			tick_cnt = '0;
			interval_cnt = '0;
			rising = 1'b1;
			duty = '0;
			mode = TEST_NONE;
			edges = '0;
			running = 1'b0;
			phase = '0;
			latched = '0;
			errors = 0;
			results = 0;
			commands = 0;
			intervals = 0;
			ramp_moves = 0;
			step_moves = 0;
			turns = 0;
			phase_moves = 0;
		endfunction

		function void apply_register(logic [CFG_INDEX_WIDTH-1:0] idx,
				logic [CFG_DATA_WIDTH-1:0] val);
			case (idx)
				CFG_PERIOD:   period = val[DUTY_WIDTH-1:0];
				CFG_MIN_DUTY: floor_duty = val[DUTY_WIDTH-1:0];
				CFG_TICKS:    interval_ticks = val[TICK_WIDTH-1:0];
				CFG_REVERSE:  reverse = val[0];
				default: ;
			endcase
		endfunction

		// A valid code moves to its phase and latches the commanded duty.
		function void commutate(logic [HALL_WIDTH-1:0] hall);
			logic [HALL_WIDTH-1:0] code;
			logic [2:0] ph;
			code = reverse ? ~hall : hall;
			ph = CODE_PHASES[code*3 +: 3];
			if (ph != 3'd0) begin
				if (ph != phase)
					phase_moves++;
				phase = ph;
				latched = duty;
			end
		endfunction

		// One test step: clamp at the bound, or turn around once the bound is reached.
		function void move_duty(int unsigned amount);
			int unsigned room;
			if (rising) begin
				if (duty < period) begin
					room = period - duty;
					duty = (amount >= room) ? period : duty + DUTY_WIDTH'(amount);
				end else begin
					rising = 1'b0;
					turns++;
				end
			end else begin
				if (duty > floor_duty) begin
					room = duty - floor_duty;
					duty = (amount >= room) ? floor_duty : duty - DUTY_WIDTH'(amount);
				end else begin
					rising = 1'b1;
					turns++;
				end
			end
		endfunction

		// Interval bookkeeping on each PWM tick.
		function void count_tick();
			tick_cnt++;
			if (tick_cnt < interval_ticks)
				return;
			tick_cnt = '0;
			interval_cnt++;
			running = (edges != '0);
			edges = '0;
			intervals++;
			if (mode == TEST_RAMP) begin
				move_duty(1);
				ramp_moves++;
			end
			if (interval_cnt >= STEP_INTERVALS) begin
				interval_cnt = '0;
				if (mode == TEST_STEP) begin
					move_duty(STEP_SIZE);
					step_moves++;
				end
			end
		endfunction

		// Outputs as they stand after the latest command.
		function rsp_t drive_now();
			rsp_t r;
			r = '0;
			case (phase)
				3'd1, 3'd2: r.duty_a = latched;
				3'd3, 3'd4: r.duty_b = latched;
				3'd5, 3'd6: r.duty_c = latched;
				default: ;
			endcase
			case (phase)
				3'd1, 3'd4: {r.enable_b, r.enable_a} = 2'b11;
				3'd2, 3'd5: {r.enable_c, r.enable_a} = 2'b11;
				3'd3, 3'd6: {r.enable_c, r.enable_b} = 2'b11;
				default: ;
			endcase
			r.phase_number = phase;
			r.running = running;
			r.duty_now = duty;
			return r;
		endfunction

		function void note_command(cmd_t c);
			int unsigned product;
			commands++;
			case (c.op)
				OP_HALL_EDGE: begin
					commutate(c.hall_bits);
					if (edges != '1)
						edges++;
				end
				OP_PWM_TICK: count_tick();
				OP_DUTY_UP: begin
					if (duty < period)
						duty++;
				end
				OP_DUTY_DOWN: begin
					if (duty > floor_duty)
						duty--;
				end
				OP_STOP: begin
					mode = TEST_NONE;
					duty = '0;
				end
				OP_SET_POSITION: begin
					product = int'(c.position) * int'(period);
					duty = DUTY_WIDTH'(product / SLIDER_FULL);
				end
				OP_START_TEST: begin
					if (c.test_select == TEST_RAMP || c.test_select == TEST_STEP)
						mode = test_mode_t'(c.test_select);
				end
				OP_REFRESH: begin
					if (!running && duty != '0)
						commutate(c.hall_bits);
				end
				default: ;
			endcase
			pending_drives.push_back(drive_now());
		endfunction

		function void compare_field(string name, logic [DUTY_WIDTH-1:0] want,
				logic [DUTY_WIDTH-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result %0d: %s expected %0d, got %0d", results, name, want, got);
			end
		endfunction

		function void check_drive(rsp_t got);
			rsp_t want;
			results++;
			if (pending_drives.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result %0d arrived with no command waiting", results);
				return;
			end
			want = pending_drives.pop_front();
			compare_field("duty_a", want.duty_a, got.duty_a);
			compare_field("duty_b", want.duty_b, got.duty_b);
			compare_field("duty_c", want.duty_c, got.duty_c);
			compare_field("enable_a", DUTY_WIDTH'(want.enable_a), DUTY_WIDTH'(got.enable_a));
			compare_field("enable_b", DUTY_WIDTH'(want.enable_b), DUTY_WIDTH'(got.enable_b));
			compare_field("enable_c", DUTY_WIDTH'(want.enable_c), DUTY_WIDTH'(got.enable_c));
			compare_field("phase_number", DUTY_WIDTH'(want.phase_number),
				DUTY_WIDTH'(got.phase_number));
			compare_field("running", DUTY_WIDTH'(want.running), DUTY_WIDTH'(got.running));
			compare_field("duty_now", want.duty_now, got.duty_now);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

	bss_cmd_if cmd_ch();
	bss_rsp_if rsp_ch();

	commutation_checker comm_check = new();

	int burst_left = 0;
	bit gap_free = 1'b0;
	bit stim_busy = 1'b0;
	int rotor = 0;
	int holds = 0;
	int settings = 0;
	int cycle_count = 0;

	bldc_six_step_commutator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			comm_check.check_drive(rsp_ch.data);
	end

	// Result side: stalls on a pattern of its own, with a long hold-off now and then.
	initial begin : result_stall
		int seg_len;
		int style;
		int spacing;
		int since_hold;
		rsp_ch.ready = 1'b0;
		since_hold = 0;
		forever begin
			if (stim_busy && since_hold >= 6) begin
				since_hold = 0;
				holds++;
				repeat (HOLD_CYCLES) @(negedge clk) rsp_ch.ready <= 1'b0;
			end else begin
				since_hold++;
				style = $urandom_range(RX_OPEN, RX_PERIODIC);
				seg_len = $urandom_range(20, 80);
				spacing = $urandom_range(2, 5);
				for (int i = 0; i < seg_len; i++) begin
					@(negedge clk);
					case (style)
						RX_OPEN:   rsp_ch.ready <= 1'b1;
						RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
						default:   rsp_ch.ready <= (i % spacing != 0);
					endcase
				end
			end
		end
	end

	function automatic cmd_t make_cmd(op_t op, logic [HALL_WIDTH-1:0] hall,
			logic [POSITION_WIDTH-1:0] pos, logic [1:0] sel);
		cmd_t c;
		c.op = op;
		c.hall_bits = hall;
		c.position = pos;
		c.test_select = sel;
		return c;
	endfunction

	// Mostly a turning rotor with duty control, plus invalid codes and rotor jumps.
	function automatic cmd_t random_command();
		cmd_t c;
		int pick;
		int hall_pick;
		c.op = OP_PWM_TICK;
		c.hall_bits = HALL_WIDTH'($urandom_range(0, 7));
		c.position = POSITION_WIDTH'($urandom_range(0, 255));
		c.test_select = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 34) begin
			c.op = OP_HALL_EDGE;
			hall_pick = $urandom_range(0, 19);
			if (hall_pick == 0) begin
				c.hall_bits = HALL_ALL_LOW;
			end else if (hall_pick == 1) begin
				c.hall_bits = HALL_ALL_HIGH;
			end else begin
				if (hall_pick == 2)
					rotor = $urandom_range(0, 5);
				else
					rotor = (rotor + 1) % 6;
				c.hall_bits = ROTOR_CODES[rotor*3 +: 3];
			end
		end else if (pick < 64) begin
			c.op = OP_PWM_TICK;
		end else if (pick < 71) begin
			c.op = OP_DUTY_UP;
		end else if (pick < 78) begin
			c.op = OP_DUTY_DOWN;
		end else if (pick < 84) begin
			c.op = OP_SET_POSITION;
		end else if (pick < 88) begin
			c.op = OP_START_TEST;
			if ($urandom_range(0, 4) != 0)
				c.test_select = $urandom_range(0, 1) ? TEST_RAMP : TEST_STEP;
		end else if (pick < 99) begin
			c.op = OP_REFRESH;
		end else begin
			c.op = OP_STOP;
		end
		return c;
	endfunction

	task automatic idle_cmd(int n);
		repeat (n) @(negedge clk) cmd_ch.valid <= 1'b0;
	endtask

	// Offer one command in bursts with random gaps, and note it at its transfer.
	task automatic send_command(cmd_t c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (!gap_free)
				idle_cmd($urandom_range(1, 12));
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		comm_check.note_command(c);
	endtask

	task automatic random_run(int n);
		stim_busy = 1'b1;
		repeat (n) send_command(random_command());
		stim_busy = 1'b0;
	endtask

	// Stop offering and wait until every expected result has come back.
	task automatic wait_results();
		@(negedge clk) cmd_ch.valid <= 1'b0;
		while (comm_check.pending_drives.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_register(logic [CFG_INDEX_WIDTH-1:0] idx,
			logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		comm_check.apply_register(idx, val);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [DUTY_WIDTH-1:0] per, logic [DUTY_WIDTH-1:0] lo,
			logic [TICK_WIDTH-1:0] ticks, logic rev);
		wait_results();
		program_register(CFG_PERIOD, CFG_DATA_WIDTH'(per));
		program_register(CFG_MIN_DUTY, CFG_DATA_WIDTH'(lo));
		program_register(CFG_TICKS, ticks);
		program_register(CFG_REVERSE, CFG_DATA_WIDTH'(rev));
		settings++;
	endtask

	initial begin : stimulus
		logic [DUTY_WIDTH-1:0] per;
		logic [DUTY_WIDTH-1:0] lo;
		logic [TICK_WIDTH-1:0] ticks;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		settings = 1;

		// Directed pass on the reset settings: invalid codes, all phases, duty limits.
		gap_free = 1'b1;
		send_command(make_cmd(OP_HALL_EDGE, HALL_ALL_LOW, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_REFRESH, 3'd5, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_SET_POSITION, 3'd0, 8'd255, TEST_NONE));
		send_command(make_cmd(OP_HALL_EDGE, HALL_ALL_HIGH, 8'd0, TEST_NONE));
		for (int i = 0; i < 6; i++)
			send_command(make_cmd(OP_HALL_EDGE, ROTOR_CODES[i*3 +: 3], 8'd0, TEST_NONE));
		send_command(make_cmd(OP_REFRESH, 3'd3, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_DUTY_UP, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_SET_POSITION, 3'd7, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_DUTY_DOWN, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_DUTY_UP, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_SET_POSITION, 3'd0, 8'd128, TEST_NONE));
		send_command(make_cmd(OP_START_TEST, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_START_TEST, 3'd0, 8'd0, TEST_INVALID));
		send_command(make_cmd(OP_START_TEST, 3'd0, 8'd0, TEST_RAMP));
		send_command(make_cmd(OP_START_TEST, 3'd0, 8'd0, TEST_STEP));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_STOP, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_SET_POSITION, 3'd0, 8'hAA, TEST_NONE));

		// Widest period, one tick per interval, reversed rotation.
		configure('1, '0, TICK_WIDTH'(1), 1'b1);
		send_command(make_cmd(OP_SET_POSITION, 3'd0, 8'd255, TEST_NONE));
		send_command(make_cmd(OP_HALL_EDGE, 3'd5, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_HALL_EDGE, HALL_ALL_HIGH, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_HALL_EDGE, HALL_ALL_LOW, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_REFRESH, 3'd1, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_REFRESH, 3'd2, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_START_TEST, 3'd0, 8'd0, TEST_RAMP));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));
		gap_free = 1'b0;
		random_run(180);
		send_command(make_cmd(OP_SET_POSITION, 3'd0, 8'd255, TEST_NONE));

		// Period of one, below the duty left from before.
		configure(DUTY_WIDTH'(1), '0, TICK_WIDTH'(1), 1'b0);
		send_command(make_cmd(OP_DUTY_UP, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_START_TEST, 3'd0, 8'd0, TEST_RAMP));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));
		random_run(120);

		// Narrow band with a floor: ramp turnarounds, without sender gaps.
		configure(DUTY_WIDTH'(40), DUTY_WIDTH'(10), TICK_WIDTH'(2), 1'b0);
		gap_free = 1'b1;
		random_run(250);
		gap_free = 1'b0;

		// Step test clamped at both ends of a band narrower than a few steps.
		configure(DUTY_WIDTH'(200), DUTY_WIDTH'(150), TICK_WIDTH'(1), 1'b1);
		random_run(220);

		// Floor above the period, and a write to an unmapped register index.
		configure(DUTY_WIDTH'(30), '1, TICK_WIDTH'(3), 1'b0);
		program_register(CFG_UNMAPPED, '1);
		random_run(100);

		// Saturate the edge count inside a very long interval, then shorten the interval.
		configure(DUTY_WIDTH'(1000), '0, '1, 1'b1);
		for (int i = 0; i < 256; i++) begin
			rotor = (rotor + 1) % 6;
			send_command(make_cmd(OP_HALL_EDGE, ROTOR_CODES[rotor*3 +: 3], 8'd0, TEST_NONE));
		end
		wait_results();
		program_register(CFG_TICKS, CFG_DATA_WIDTH'(1));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_REFRESH, 3'd6, 8'd0, TEST_NONE));
		send_command(make_cmd(OP_PWM_TICK, 3'd0, 8'd0, TEST_NONE));

		// Random settings: small periods half the time, and mostly short intervals.
		for (int k = 0; k < 4; k++) begin
			per = $urandom_range(0, 1) ? DUTY_WIDTH'($urandom_range(1, 300))
				: DUTY_WIDTH'($urandom_range(1, 65535));
			lo = ($urandom_range(0, 5) == 0) ? DUTY_WIDTH'($urandom_range(0, 65535))
				: DUTY_WIDTH'($urandom_range(0, per));
			ticks = ($urandom_range(0, 3) == 0) ? TICK_WIDTH'($urandom_range(1, 60))
				: TICK_WIDTH'($urandom_range(1, 4));
			configure(per, lo, ticks, 1'($urandom_range(0, 1)));
			gap_free = (k == 2);
			random_run(120);
		end
		gap_free = 1'b0;

		// Drain, let the pipeline settle, then report.
		wait_results();
		repeat (10) @(posedge clk);
		comm_check.errors += comm_check.pending_drives.size();
		$display("Run covered %0d commands and %0d results over %0d register settings.",
			comm_check.commands, comm_check.results, settings);
		$display("%0d intervals, %0d ramp steps, %0d step-test steps, %0d turnarounds, %0d %s",
			comm_check.intervals, comm_check.ramp_moves, comm_check.step_moves,
			comm_check.turns, holds, "long receiver hold-offs.");
		if (comm_check.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ----- bldc_six_step_commutator_core.f -----
hw/rtl/bss_pkg.sv
hw/rtl/bss_if.sv
hw/rtl/bldc_six_step_commutator_core.sv
test/tb_top.sv
